[sv/cbe_pkg.sv]
// shared widths, defaults and register indexes of the cubic bezier evaluator
`timescale 1ns / 1ps

package cbe_pkg;

    // default number of fraction bits of points and tau
    localparam int FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int TAU_W     = 18;
    localparam int POINT_W   = 32;
    localparam int DERIV_W   = 36;

    // configuration port
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    // pipeline depth: tau clamp stage plus the axis datapath stages
    localparam int AXIS_STAGES = 9;
    localparam int NUM_STAGES  = AXIS_STAGES + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd7;

endpackage

[sv/cubic_bezier_evaluator.sv]
// top level of the cubic bezier evaluator: config registers, clamp, flow control
//
//  channel  direction  ports                                      width
//  s_       in         s_valid s_ready s_tau_in                   18
//  m_       out        m_valid m_ready m_pos_x/y m_deriv_x/y      32 / 36
//  cfg      in         cfg_wr_en cfg_index cfg_wr_data            3 / 32
//
// one word accepted per cycle while there is room; clamp stage plus nine
// datapath stages, three per de casteljau level: difference, multiply, add.
// aresetn is synchronous and clears the config registers and all valid bits.
// each stage holds when it is full and the stage after it cannot move, so
// bubbles close up and a word is still taken while the output waits.
`timescale 1ns / 1ps

module cubic_bezier_evaluator #(
    parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [cbe_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cbe_pkg::POINT_W-1:0]           cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [cbe_pkg::TAU_W-1:0]      s_tau_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cbe_pkg::POINT_W-1:0]    m_pos_x,
    output logic signed [cbe_pkg::POINT_W-1:0]    m_pos_y,
    output logic signed [cbe_pkg::DERIV_W-1:0]    m_deriv_x,
    output logic signed [cbe_pkg::DERIV_W-1:0]    m_deriv_y
);

    localparam int NS = cbe_pkg::NUM_STAGES;
    localparam int TW = FRAC_BITS + 1;
    localparam int CW = (cbe_pkg::TAU_W > FRAC_BITS + 2) ? cbe_pkg::TAU_W : FRAC_BITS + 2;
    localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< FRAC_BITS;

    logic signed [cbe_pkg::POINT_W-1:0] cfg_reg [cbe_pkg::NUM_REGS];
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] rdy;
    logic [TW-1:0] tau_reg;
    logic [TW-1:0] tau_next;
    logic signed [CW-1:0] tau_ext;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cbe_pkg::NUM_REGS; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_index] <= $signed(cfg_wr_data);
        end
    end

    // stage ready chain, from the output back to the input
    always_comb begin
        rdy[NS-1] = !v_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    // valid bits move with the data
    always_comb begin
        v_next[0] = rdy[0] ? s_valid : v_reg[0];
        for (int k = 1; k < NS; k++) begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // clamp tau to 0 .. 1.0
    always_comb begin
        tau_ext = CW'(s_tau_in);
        if (tau_ext < 0) begin
            tau_next = '0;
        end else if (tau_ext > ONE_C) begin
            tau_next = ONE_C[TW-1:0];
        end else begin
            tau_next = tau_ext[TW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            tau_reg <= tau_next;
        end
    end

    // datapath, one per axis
    cbe_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .aclk     (aclk),
        .stage_en (rdy[NS-1:1]),
        .tau      (tau_reg),
        .p0       (cfg_reg[cbe_pkg::REG_START_X]),
        .p1       (cfg_reg[cbe_pkg::REG_CTRL1_X]),
        .p2       (cfg_reg[cbe_pkg::REG_CTRL2_X]),
        .p3       (cfg_reg[cbe_pkg::REG_END_X]),
        .pos      (m_pos_x),
        .deriv    (m_deriv_x)
    );

    cbe_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .aclk     (aclk),
        .stage_en (rdy[NS-1:1]),
        .tau      (tau_reg),
        .p0       (cfg_reg[cbe_pkg::REG_START_Y]),
        .p1       (cfg_reg[cbe_pkg::REG_CTRL1_Y]),
        .p2       (cfg_reg[cbe_pkg::REG_CTRL2_Y]),
        .p3       (cfg_reg[cbe_pkg::REG_END_Y]),
        .pos      (m_pos_y),
        .deriv    (m_deriv_y)
    );

    assign s_ready = rdy[0];
    assign m_valid = v_reg[NS-1];

    // input only stalls when every stage is full and the output is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && (&v_reg)))
        else $error("input stalled with room in the pipeline");

    // words in flight: one more after an accept without a take
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !(m_valid && m_ready))
        |=> ($countones(v_reg) == $past($countones(v_reg)) + 1))
        else $error("accepted word lost in pipeline");

    // one fewer after a take without an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !(s_valid && s_ready))
        |=> ($countones(v_reg) + 1 == $past($countones(v_reg))))
        else $error("delivered word repeated in pipeline");

    // clamped tau never exceeds 1.0
    assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[0] |-> (tau_reg <= ONE_C[TW-1:0]))
        else $error("tau clamp out of range");

    // derivative stays within the 35-bit range of 3 * 33-bit terms
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_deriv_x[cbe_pkg::DERIV_W-1] == m_deriv_x[cbe_pkg::DERIV_W-2])
                  && (m_deriv_y[cbe_pkg::DERIV_W-1] == m_deriv_y[cbe_pkg::DERIV_W-2])))
        else $error("derivative beyond its expected range");

endmodule

[sv/cbe_axis.sv]
// one coordinate axis: pipelined de casteljau position and derivative
`timescale 1ns / 1ps

module cbe_axis #(
    parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic [cbe_pkg::AXIS_STAGES-1:0]      stage_en,
    input  logic [FRAC_BITS:0]                   tau,
    input  logic signed [cbe_pkg::POINT_W-1:0]   p0,
    input  logic signed [cbe_pkg::POINT_W-1:0]   p1,
    input  logic signed [cbe_pkg::POINT_W-1:0]   p2,
    input  logic signed [cbe_pkg::POINT_W-1:0]   p3,
    output logic signed [cbe_pkg::POINT_W-1:0]   pos,
    output logic signed [cbe_pkg::DERIV_W-1:0]   deriv
);

    localparam int PW  = cbe_pkg::POINT_W;
    localparam int TW  = FRAC_BITS + 1;
    localparam int TSW = TW + 1;
    localparam int DW  = PW + 1;
    localparam int EW  = PW + 2;
    localparam int MDW = DW + TSW;
    localparam int MEW = EW + TSW;
    localparam int G3W = DW + 2;

    // base + round-half-up of prod / 2^FRAC_BITS, position width
    function automatic logic signed [PW-1:0] rnd_add_pt(
        input logic signed [PW-1:0]  base,
        input logic signed [MDW-1:0] prod
    );
        logic signed [MDW-1:0] sh;
        logic signed [MDW-1:0] rb;
        logic signed [MDW-1:0] sum;
        sh  = prod >>> FRAC_BITS;
        rb  = $signed({{(MDW-1){1'b0}}, prod[FRAC_BITS-1]});
        sum = MDW'(base) + sh + rb;
        return sum[PW-1:0];
    endfunction

    // same for the derivative terms, one bit wider
    function automatic logic signed [DW-1:0] rnd_add_dv(
        input logic signed [DW-1:0]  base,
        input logic signed [MEW-1:0] prod
    );
        logic signed [MEW-1:0] sh;
        logic signed [MEW-1:0] rb;
        logic signed [MEW-1:0] sum;
        sh  = prod >>> FRAC_BITS;
        rb  = $signed({{(MEW-1){1'b0}}, prod[FRAC_BITS-1]});
        sum = MEW'(base) + sh + rb;
        return sum[DW-1:0];
    endfunction

    // tau delay line, one copy per stage that needs it
    logic [TW-1:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;

    logic signed [DW-1:0]  d01_1_reg, d12_1_reg, d23_1_reg;
    logic signed [MDW-1:0] ma_2_reg, mb_2_reg, mc_2_reg;
    logic signed [EW-1:0]  e0_2_reg, e1_2_reg;
    logic signed [DW-1:0]  d01_2_reg, d12_2_reg;
    logic signed [PW-1:0]  a_3_reg, b_3_reg, c_3_reg;
    logic signed [MEW-1:0] me0_3_reg, me1_3_reg;
    logic signed [DW-1:0]  d01_3_reg, d12_3_reg;
    logic signed [DW-1:0]  da_4_reg, db_4_reg, q0_4_reg, q1_4_reg;
    logic signed [PW-1:0]  a_4_reg, b_4_reg;
    logic signed [MDW-1:0] mda_5_reg, mdb_5_reg;
    logic signed [PW-1:0]  a_5_reg, b_5_reg;
    logic signed [EW-1:0]  dq_5_reg;
    logic signed [DW-1:0]  q0_5_reg;
    logic signed [PW-1:0]  d_6_reg, e_6_reg;
    logic signed [MEW-1:0] mq_6_reg;
    logic signed [DW-1:0]  q0_6_reg;
    logic signed [DW-1:0]  de_7_reg, g_7_reg;
    logic signed [PW-1:0]  d_7_reg;
    logic signed [MDW-1:0] mp_8_reg;
    logic signed [PW-1:0]  d_8_reg;
    logic signed [G3W-1:0] g3_8_reg;
    logic signed [PW-1:0]  pos_reg;
    logic signed [cbe_pkg::DERIV_W-1:0] deriv_reg;

    logic signed [TSW-1:0] ts1, ts2, ts4, ts5, ts7;

    assign ts1 = $signed({1'b0, t1_reg});
    assign ts2 = $signed({1'b0, t2_reg});
    assign ts4 = $signed({1'b0, t4_reg});
    assign ts5 = $signed({1'b0, t5_reg});
    assign ts7 = $signed({1'b0, t7_reg});

    // stage 1: first-level differences
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            t1_reg    <= tau;
            d01_1_reg <= DW'(p1) - DW'(p0);
            d12_1_reg <= DW'(p2) - DW'(p1);
            d23_1_reg <= DW'(p3) - DW'(p2);
        end
    end

    // stage 2: first-level products, second differences for the derivative
    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            t2_reg    <= t1_reg;
            ma_2_reg  <= d01_1_reg * ts1;
            mb_2_reg  <= d12_1_reg * ts1;
            mc_2_reg  <= d23_1_reg * ts1;
            e0_2_reg  <= EW'(d12_1_reg) - EW'(d01_1_reg);
            e1_2_reg  <= EW'(d23_1_reg) - EW'(d12_1_reg);
            d01_2_reg <= d01_1_reg;
            d12_2_reg <= d12_1_reg;
        end
    end

    // stage 3: first-level points, derivative products
    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            t3_reg    <= t2_reg;
            a_3_reg   <= rnd_add_pt(p0, ma_2_reg);
            b_3_reg   <= rnd_add_pt(p1, mb_2_reg);
            c_3_reg   <= rnd_add_pt(p2, mc_2_reg);
            me0_3_reg <= e0_2_reg * ts2;
            me1_3_reg <= e1_2_reg * ts2;
            d01_3_reg <= d01_2_reg;
            d12_3_reg <= d12_2_reg;
        end
    end

    // stage 4: second-level differences, quadratic derivative points
    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            t4_reg   <= t3_reg;
            da_4_reg <= DW'(b_3_reg) - DW'(a_3_reg);
            db_4_reg <= DW'(c_3_reg) - DW'(b_3_reg);
            a_4_reg  <= a_3_reg;
            b_4_reg  <= b_3_reg;
            q0_4_reg <= rnd_add_dv(d01_3_reg, me0_3_reg);
            q1_4_reg <= rnd_add_dv(d12_3_reg, me1_3_reg);
        end
    end

    // stage 5: second-level products, derivative difference
    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            t5_reg    <= t4_reg;
            mda_5_reg <= da_4_reg * ts4;
            mdb_5_reg <= db_4_reg * ts4;
            a_5_reg   <= a_4_reg;
            b_5_reg   <= b_4_reg;
            dq_5_reg  <= EW'(q1_4_reg) - EW'(q0_4_reg);
            q0_5_reg  <= q0_4_reg;
        end
    end

    // stage 6: second-level points, last derivative product
    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            t6_reg   <= t5_reg;
            d_6_reg  <= rnd_add_pt(a_5_reg, mda_5_reg);
            e_6_reg  <= rnd_add_pt(b_5_reg, mdb_5_reg);
            mq_6_reg <= dq_5_reg * ts5;
            q0_6_reg <= q0_5_reg;
        end
    end

    // stage 7: last position difference, derivative before the factor of 3
    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            t7_reg   <= t6_reg;
            de_7_reg <= DW'(e_6_reg) - DW'(d_6_reg);
            d_7_reg  <= d_6_reg;
            g_7_reg  <= rnd_add_dv(q0_6_reg, mq_6_reg);
        end
    end

    // stage 8: last position product, derivative times 3
    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            mp_8_reg <= de_7_reg * ts7;
            d_8_reg  <= d_7_reg;
            g3_8_reg <= G3W'(g_7_reg) + (G3W'(g_7_reg) <<< 1);
        end
    end

    // stage 9: output word; 3 * 33-bit term always fits the derivative field
    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            pos_reg   <= rnd_add_pt(d_8_reg, mp_8_reg);
            deriv_reg <= {{(cbe_pkg::DERIV_W-G3W){g3_8_reg[G3W-1]}}, g3_8_reg};
        end
    end

    assign pos   = pos_reg;
    assign deriv = deriv_reg;

endmodule

[test/cubic_bezier_evaluator_test.sv]
// self-checking testbench for the cubic bezier evaluator: position and derivative per tau word
`timescale 1ns / 1ps

module cubic_bezier_evaluator_test;

    localparam int FRAC = cbe_pkg::FRAC_BITS_DEF;
    localparam int PW = cbe_pkg::POINT_W;
    localparam int DVW = cbe_pkg::DERIV_W;
    localparam int TAUW = cbe_pkg::TAU_W;
    localparam int NREGS = cbe_pkg::NUM_REGS;
    localparam int IDXW = cbe_pkg::CFG_IDX_W;
    localparam longint ONE = longint'(1) <<< FRAC;
    localparam longint DERIV_MAX = (longint'(1) <<< (DVW - 1)) - 1;
    localparam longint DERIV_MIN = -(longint'(1) <<< (DVW - 1));
    localparam int CYCLE_LIMIT = 400000;

    // kinds of control point sets
    localparam int PTS_RANDOM = 0;
    localparam int PTS_SMALL  = 1;
    localparam int PTS_MAX    = 2;
    localparam int PTS_MIN    = 3;
    localparam int PTS_ZIGZAG = 4;

    // idling patterns
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct {
        logic signed [PW-1:0] pos_x;
        logic signed [PW-1:0] pos_y;
        logic signed [DVW-1:0] deriv_x;
        logic signed [DVW-1:0] deriv_y;
    } curve_sample_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [IDXW-1:0] cfg_index = '0;
    logic [PW-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [TAUW-1:0] s_tau_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [PW-1:0] m_pos_x;
    logic signed [PW-1:0] m_pos_y;
    logic signed [DVW-1:0] m_deriv_x;
    logic signed [DVW-1:0] m_deriv_y;

    // our copy of the control points, indexed like the register file
    logic signed [PW-1:0] ctrl_pts [NREGS];

    logic signed [TAUW-1:0] tau_queue [$];
    curve_sample_t expected_samples [$];
    logic s_took = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    cubic_bezier_evaluator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_tau_in    (s_tau_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pos_x     (m_pos_x),
        .m_pos_y     (m_pos_y),
        .m_deriv_x   (m_deriv_x),
        .m_deriv_y   (m_deriv_y)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one interpolation step, rounded half up
    function automatic longint interp(input longint a, input longint b, input longint t);
        longint prod;
        prod = (b - a) * t + (longint'(1) <<< (FRAC - 1));
        return a + (prod >>> FRAC);
    endfunction

    // de casteljau on one axis, derivative from the control point differences
    function automatic void curve_axis(input longint p0, input longint p1, input longint p2,
                                       input longint p3, input longint t,
                                       output longint pos, output longint slope);
        longint a, b, c, d, e, q0, q1;
        a = interp(p0, p1, t);
        b = interp(p1, p2, t);
        c = interp(p2, p3, t);
        d = interp(a, b, t);
        e = interp(b, c, t);
        pos = interp(d, e, t);
        q0 = interp(p1 - p0, p2 - p1, t);
        q1 = interp(p2 - p1, p3 - p2, t);
        slope = 3 * interp(q0, q1, t);
        if (slope > DERIV_MAX)
            slope = DERIV_MAX;
        if (slope < DERIV_MIN)
            slope = DERIV_MIN;
    endfunction

    function automatic curve_sample_t curve_at(input logic signed [TAUW-1:0] tau);
        curve_sample_t s;
        longint t, px, py, dx, dy;
        t = longint'(tau);
        if (t < 0)
            t = 0;
        if (t > ONE)
            t = ONE;
        curve_axis(ctrl_pts[cbe_pkg::REG_START_X], ctrl_pts[cbe_pkg::REG_CTRL1_X],
                   ctrl_pts[cbe_pkg::REG_CTRL2_X], ctrl_pts[cbe_pkg::REG_END_X], t, px, dx);
        curve_axis(ctrl_pts[cbe_pkg::REG_START_Y], ctrl_pts[cbe_pkg::REG_CTRL1_Y],
                   ctrl_pts[cbe_pkg::REG_CTRL2_Y], ctrl_pts[cbe_pkg::REG_END_Y], t, py, dy);
        s.pos_x = px[PW-1:0];
        s.pos_y = py[PW-1:0];
        s.deriv_x = dx[DVW-1:0];
        s.deriv_y = dy[DVW-1:0];
        return s;
    endfunction

    task automatic check_field(input string name, input logic [DVW-1:0] want,
                               input logic [DVW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // input driver: next tau word once the current one is taken; output ready drawn at random
    always @(negedge aclk) begin
        if (!s_valid || s_took) begin
            if (tau_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tau_in <= tau_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // predict on accepted words, check result words in order
    always @(posedge aclk) begin
        curve_sample_t want;
        s_took <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            expected_samples.push_back(curve_at(s_tau_in));
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %h %h %h %h",
                         $time, m_pos_x, m_pos_y, m_deriv_x, m_deriv_y);
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                check_field("pos_x", DVW'(want.pos_x), DVW'(m_pos_x));
                check_field("pos_y", DVW'(want.pos_y), DVW'(m_pos_y));
                check_field("deriv_x", want.deriv_x, m_deriv_x);
                check_field("deriv_y", want.deriv_y, m_deriv_y);
            end
        end
    end

    // run time limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // write all eight control point registers
    task automatic program_points(input int kind);
        logic [PW-1:0] vals [NREGS];
        for (int i = 0; i < NREGS; i++) begin
            case (kind)
                PTS_RANDOM: vals[i] = $urandom;
                PTS_SMALL:  vals[i] = $urandom_range(32'h0010_0000) - 32'h0008_0000;
                PTS_MAX:    vals[i] = 32'h7FFF_FFFF;
                PTS_MIN:    vals[i] = 32'h8000_0000;
                default:    vals[i] = 32'h0;
            endcase
        end
        if (kind == PTS_ZIGZAG) begin
            vals[cbe_pkg::REG_START_X] = 32'h8000_0000;
            vals[cbe_pkg::REG_CTRL1_X] = 32'h7FFF_FFFF;
            vals[cbe_pkg::REG_CTRL2_X] = 32'h8000_0000;
            vals[cbe_pkg::REG_END_X]   = 32'h7FFF_FFFF;
            vals[cbe_pkg::REG_START_Y] = 32'h7FFF_FFFF;
            vals[cbe_pkg::REG_CTRL1_Y] = 32'h8000_0000;
            vals[cbe_pkg::REG_CTRL2_Y] = 32'h7FFF_FFFF;
            vals[cbe_pkg::REG_END_Y]   = 32'h8000_0000;
        end
        for (int i = 0; i < NREGS; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= IDXW'(i);
            cfg_wr_data <= vals[i];
            ctrl_pts[i] = vals[i];
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            IDLE_SEND: begin send_idle_pct = 82; recv_stall_pct = 0; end
            IDLE_RECV: begin send_idle_pct = 0; recv_stall_pct = 82; end
            IDLE_BOTH: begin send_idle_pct = 22; recv_stall_pct = 22; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    task automatic drain();
        while (tau_queue.size() != 0 || s_valid || expected_samples.size() != 0)
            @(negedge aclk);
    endtask

    task automatic push_directed();
        logic signed [TAUW-1:0] edges [12];
        edges = '{18'sh20000, -18'sd65536, -18'sd1, 18'sd0, 18'sd1, 18'sd16384,
                  18'sd32767, 18'sd32768, 18'sd65535, 18'sd65536, 18'sd65537, 18'sd131071};
        foreach (edges[i])
            tau_queue.push_back(edges[i]);
    endtask

    initial begin
        logic signed [TAUW-1:0] tau;
        for (int i = 0; i < NREGS; i++)
            ctrl_pts[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: clamp edges on the reset points and on a full-swing zigzag
        set_idling(IDLE_NONE);
        push_directed();
        drain();
        program_points(PTS_ZIGZAG);
        push_directed();
        drain();

        // random phases, mostly in-range tau, idling pattern rotating
        for (int ph = 0; ph < 10; ph++) begin
            program_points(ph % 5);
            set_idling(ph % 4);
            for (int n = 0; n < 90; n++) begin
                case ($urandom_range(9))
                    0: tau = TAUW'($urandom);
                    1: begin
                        case ($urandom_range(5))
                            0: tau = -18'sd1;
                            1: tau = 18'sd0;
                            2: tau = 18'sd1;
                            3: tau = 18'sd65535;
                            4: tau = 18'sd65536;
                            default: tau = 18'sd65537;
                        endcase
                    end
                    default: tau = TAUW'($urandom_range(65536));
                endcase
                tau_queue.push_back(tau);
            end
            drain();
        end

        repeat (cbe_pkg::NUM_STAGES + 10) @(posedge aclk);
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[cubic_bezier_evaluator.f]
sv/cbe_pkg.sv
sv/cbe_axis.sv
sv/cubic_bezier_evaluator.sv
test/cubic_bezier_evaluator_test.sv
